[rtl/xbig_pkg.sv]
package xbig_pkg;

    // Number of bounded draws that an averaged request sums; a power of two.
    localparam int AVG_COUNT = 4;
    localparam int AVG_SHIFT = $clog2(AVG_COUNT);
    localparam int SUM_W     = 32 + AVG_SHIFT + 1;
    localparam int COUNT_W   = $clog2(AVG_COUNT + 1);

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] INIT_X = 32'd123456789;
    localparam logic [31:0] INIT_Y = 32'd362436069;
    localparam logic [31:0] INIT_Z = 32'd521288629;
    localparam logic [31:0] INIT_W = 32'd88675123;

    typedef enum logic [1:0] {
        OP_RAW     = 2'd0,
        OP_BELOW   = 2'd1,
        OP_BETWEEN = 2'd2,
        OP_AVERAGE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMIT,
        S_DRAW,
        S_MOD,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] first_bound;
        logic signed [31:0] second_bound;
    } t_req;

    typedef struct packed {
        logic        [31:0] raw_word;
        logic signed [31:0] int_value;
    } t_rsp;

endpackage

[rtl/xorshift_bounded_int_generator.sv]
// A request is answered with no draw, with one raw word, with one bounded draw or with an averaged
// set of bounded draws; every rejected word adds one more draw.
// The block takes one request at a time; the 32-step shared remainder unit runs once for the limit
// and once per accepted word.
// The next request is taken once the result has moved into the output register.
// Reset (synchronous, active low) loads the seed-zero state words and empties the output register.
module xorshift_bounded_int_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  xbig_pkg::t_req      i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output xbig_pkg::t_rsp      o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_seed
);

    xbig_pkg::t_state r_state, n_state;

    logic [31:0] r_x, r_y, r_z, r_w;
    logic [31:0] n_x, n_y, n_z, n_w;

    logic [30:0]        r_range, n_range;
    logic signed [31:0] r_base, n_base;
    logic [31:0]        r_lim, n_lim;
    logic signed [xbig_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [xbig_pkg::COUNT_W-1:0]      r_count, n_count;
    logic r_avg, n_avg;
    logic r_raw, n_raw;

    logic [31:0]                    r_div, n_div;
    logic [30:0]                    r_rem, n_rem;
    logic [xbig_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    xbig_pkg::t_rsp r_out, n_out;
    logic           r_out_valid, n_out_valid;

    logic               in_fire;
    logic               cfg_fire;
    logic               div_done;
    logic               out_free;
    logic [31:0]        mix_word;
    logic [31:0]        draw_w;
    logic               reject;
    logic [31:0]        shifted;
    logic [32:0]        trial;
    logic [30:0]        rem_next;
    logic signed [31:0] lo, hi;
    logic signed [32:0] diff;
    logic               span_big;
    logic               below_skip;
    logic signed [xbig_pkg::SUM_W-1:0] sum_adj;
    logic signed [xbig_pkg::SUM_W-1:0] quotient;
    logic signed [31:0] final_int;

    assign o_in_ready  = (r_state == xbig_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign div_done = (r_cnt == xbig_pkg::DIV_CNT_W'(xbig_pkg::DIV_STEPS - 1));

    // One xorshift128 step.
    assign mix_word = r_x ^ (r_x << 11);
    assign draw_w   = (r_w ^ (r_w >> 19)) ^ (mix_word ^ (mix_word >> 8));
    assign reject   = (draw_w >= r_lim);

    // Restoring remainder step: one dividend bit per cycle.
    assign shifted  = {r_rem, r_div[31]};
    assign trial    = {1'b0, shifted} - {2'b00, r_range};
    assign rem_next = trial[32] ? shifted[30:0] : trial[30:0];

    // Request decode.
    assign lo   = (i_in_data.first_bound < i_in_data.second_bound) ?
                  i_in_data.first_bound : i_in_data.second_bound;
    assign hi   = (i_in_data.first_bound < i_in_data.second_bound) ?
                  i_in_data.second_bound : i_in_data.first_bound;
    assign diff = 33'(hi) - 33'(lo);
    // The span is diff + 1; it is too wide for a signed int when diff reaches 2^31 - 1.
    assign span_big   = (diff[32:31] != 2'b00) || (diff[30:0] == '1);
    assign below_skip = i_in_data.first_bound[31] || (i_in_data.first_bound == 32'sd0);

    // Average with truncation toward zero.
    assign sum_adj  = r_sum + (r_sum[xbig_pkg::SUM_W-1] ?
                      xbig_pkg::SUM_W'(xbig_pkg::AVG_COUNT - 1) : xbig_pkg::SUM_W'(0));
    assign quotient = sum_adj >>> xbig_pkg::AVG_SHIFT;
    assign final_int = r_avg ? quotient[31:0] : r_sum[31:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            xbig_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_in_data.op)
                        xbig_pkg::OP_RAW:   n_state = xbig_pkg::S_DRAW;
                        xbig_pkg::OP_BELOW: n_state = below_skip ? xbig_pkg::S_FINISH
                                                                 : xbig_pkg::S_LIMIT;
                        default:            n_state = span_big ? xbig_pkg::S_FINISH
                                                               : xbig_pkg::S_LIMIT;
                    endcase
                end
            end
            xbig_pkg::S_LIMIT: begin
                if (div_done) begin
                    n_state = xbig_pkg::S_DRAW;
                end
            end
            xbig_pkg::S_DRAW: begin
                if (r_raw) begin
                    n_state = xbig_pkg::S_FINISH;
                end else if (!reject) begin
                    n_state = xbig_pkg::S_MOD;
                end
            end
            xbig_pkg::S_MOD: begin
                if (div_done) begin
                    n_state = (r_count == xbig_pkg::COUNT_W'(1)) ? xbig_pkg::S_FINISH
                                                                 : xbig_pkg::S_DRAW;
                end
            end
            xbig_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = xbig_pkg::S_IDLE;
                end
            end
            default: n_state = xbig_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_w         = r_w;
        n_range     = r_range;
        n_base      = r_base;
        n_lim       = r_lim;
        n_sum       = r_sum;
        n_count     = r_count;
        n_avg       = r_avg;
        n_raw       = r_raw;
        n_div       = r_div;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            xbig_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_sum   = '0;
                    n_avg   = 1'b0;
                    n_raw   = 1'b0;
                    n_count = xbig_pkg::COUNT_W'(1);
                    n_div   = '1;
                    n_rem   = '0;
                    n_cnt   = '0;
                    case (i_in_data.op)
                        xbig_pkg::OP_RAW: begin
                            n_raw = 1'b1;
                        end
                        xbig_pkg::OP_BELOW: begin
                            n_range = i_in_data.first_bound[30:0];
                            n_base  = '0;
                        end
                        default: begin
                            n_range = diff[30:0] + 31'd1;
                            n_base  = lo;
                            // An overflowing span answers the lower bound and draws nothing.
                            if (span_big) begin
                                n_sum = xbig_pkg::SUM_W'(lo);
                            end else if (i_in_data.op == xbig_pkg::OP_AVERAGE) begin
                                n_avg   = 1'b1;
                                n_count = xbig_pkg::COUNT_W'(xbig_pkg::AVG_COUNT);
                            end
                        end
                    endcase
                end
            end
            xbig_pkg::S_LIMIT: begin
                n_div = {r_div[30:0], 1'b0};
                n_rem = rem_next;
                n_cnt = r_cnt + 1'b1;
                if (div_done) begin
                    n_lim = ~{1'b0, rem_next};
                end
            end
            xbig_pkg::S_DRAW: begin
                n_x   = r_y;
                n_y   = r_z;
                n_z   = r_w;
                n_w   = draw_w;
                n_div = draw_w;
                n_rem = '0;
                n_cnt = '0;
            end
            xbig_pkg::S_MOD: begin
                n_div = {r_div[30:0], 1'b0};
                n_rem = rem_next;
                n_cnt = r_cnt + 1'b1;
                if (div_done) begin
                    n_sum   = r_sum + xbig_pkg::SUM_W'(r_base)
                              + xbig_pkg::SUM_W'({1'b0, rem_next});
                    n_count = r_count - 1'b1;
                end
            end
            xbig_pkg::S_FINISH: begin
                if (out_free) begin
                    n_out.raw_word  = r_w;
                    n_out.int_value = final_int;
                    n_out_valid     = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase

        // A seed write reloads the whole generator state.
        if (cfg_fire) begin
            n_x = xbig_pkg::INIT_X;
            n_y = xbig_pkg::INIT_Y;
            n_z = xbig_pkg::INIT_Z;
            n_w = (i_cfg_seed != 32'd0) ? i_cfg_seed : xbig_pkg::INIT_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xbig_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_x         <= xbig_pkg::INIT_X;
            r_y         <= xbig_pkg::INIT_Y;
            r_z         <= xbig_pkg::INIT_Z;
            r_w         <= xbig_pkg::INIT_W;
            r_count     <= '0;
            r_cnt       <= '0;
            r_raw       <= 1'b0;
            r_avg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_w         <= n_w;
            r_count     <= n_count;
            r_cnt       <= n_cnt;
            r_raw       <= n_raw;
            r_avg       <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
        r_base  <= n_base;
        r_lim   <= n_lim;
        r_sum   <= n_sum;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("request accepted but block still reports ready");

    a_rem_below_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xbig_pkg::S_MOD || r_state == xbig_pkg::S_LIMIT) |-> r_rem < r_range)
        else $error("partial remainder not below the range");

    a_accepted_word_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xbig_pkg::S_MOD && r_cnt == '0) |-> r_div < r_lim)
        else $error("rejected word passed on to the remainder unit");

    a_draws_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xbig_pkg::S_DRAW && !r_raw) |-> r_count != '0)
        else $error("bounded draw started with no draws left");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xbig_pkg::S_FINISH && out_free) |=> r_out_valid)
        else $error("finished request left no beat in the output register");
`endif

endmodule

[sim/tb_xorshift_bounded_int_generator.sv]
`timescale 1ns / 1ps

module tb_xorshift_bounded_int_generator;

    localparam int S32_MIN = 32'sh8000_0000;
    localparam int S32_MAX = 32'sh7FFF_FFFF;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 317;

    // Keeps its own copy of the four xorshift words and predicts each response.
    class xorshift_scoreboard;
        bit [31:0]      word_x, word_y, word_z, word_w;
        xbig_pkg::t_rsp awaited_rsps[$];
        int             errors;

        function new();
            errors = 0;
            load_seed(32'd0);
        endfunction

        function void load_seed(bit [31:0] seed);
            word_x = xbig_pkg::INIT_X;
            word_y = xbig_pkg::INIT_Y;
            word_z = xbig_pkg::INIT_Z;
            word_w = (seed != 32'd0) ? seed : xbig_pkg::INIT_W;
        endfunction

        function bit [31:0] next_word();
            bit [31:0] t;
            t = word_x ^ (word_x << 11);
            word_x = word_y;
            word_y = word_z;
            word_z = word_w;
            word_w = (word_w ^ (word_w >> 19)) ^ (t ^ (t >> 8));
            return word_w;
        endfunction

        // Rejection keeps the draw unbiased; a range outside 1..2^31-1 draws nothing.
        function longint uniform_below(longint range);
            bit [31:0] r, lim, n;
            if (range <= 0 || range > longint'(S32_MAX))
                return 0;
            r = range[31:0];
            lim = 32'hFFFF_FFFF - (32'hFFFF_FFFF % r);
            do begin
                n = next_word();
            end while (n >= lim);
            return {32'd0, n % r};
        endfunction

        function longint uniform_between(longint a, longint b);
            longint lo, hi, span;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            span = hi - lo + 1;
            if (span > longint'(S32_MAX))
                return lo;
            return lo + uniform_below(span);
        endfunction

        function void note_request(xbig_pkg::t_req req);
            longint         a, b, total, value;
            xbig_pkg::t_rsp exp_rsp;
            a = $signed(req.first_bound);
            b = $signed(req.second_bound);
            value = 0;
            case (req.op)
                xbig_pkg::OP_RAW: begin
                    void'(next_word());
                end
                xbig_pkg::OP_BELOW: begin
                    value = uniform_below(a);
                end
                xbig_pkg::OP_BETWEEN: begin
                    value = uniform_between(a, b);
                end
                default: begin
                    total = 0;
                    for (int i = 0; i < xbig_pkg::AVG_COUNT; i++)
                        total += uniform_between(a, b);
                    value = total / xbig_pkg::AVG_COUNT;
                end
            endcase
            exp_rsp.raw_word = word_w;
            exp_rsp.int_value = value[31:0];
            awaited_rsps.push_back(exp_rsp);
        endfunction

        function void check_result(xbig_pkg::t_rsp got);
            xbig_pkg::t_rsp exp_rsp;
            if (awaited_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, raw_word %h int_value %0d",
                         $time, got.raw_word, got.int_value);
                return;
            end
            exp_rsp = awaited_rsps.pop_front();
            if (got.raw_word !== exp_rsp.raw_word) begin
                errors++;
                $display("%0t: raw_word mismatch, expected %h, actual %h",
                         $time, exp_rsp.raw_word, got.raw_word);
            end
            if (got.int_value !== exp_rsp.int_value) begin
                errors++;
                $display("%0t: int_value mismatch, expected %0d, actual %0d",
                         $time, exp_rsp.int_value, got.int_value);
            end
        endfunction

        function int pending();
            return awaited_rsps.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    xbig_pkg::t_req req_data;
    logic           rsp_valid;
    logic           rsp_ready;
    xbig_pkg::t_rsp rsp_data;
    logic           seed_valid;
    logic           seed_ready;
    logic [31:0]    seed_value;

    xorshift_scoreboard sb;
    int send_quiet = 0;
    int recv_quiet = 0;

    xorshift_bounded_int_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data),
        .i_cfg_valid (seed_valid),
        .o_cfg_ready (seed_ready),
        .i_cfg_seed  (seed_value)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly random waits, with occasional runs of back-to-back beats.
    function automatic int draw_gap(ref int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic xbig_pkg::t_req make_req(xbig_pkg::t_op op, int a, int b);
        xbig_pkg::t_req req;
        req.op = op;
        req.first_bound = a;
        req.second_bound = b;
        return req;
    endfunction

    function automatic int pick_bound();
        case ($urandom_range(0, 4))
            0: return int'($urandom_range(0, 32)) - 16;
            1: return $urandom();
            2: begin
                case ($urandom_range(0, 5))
                    0: return S32_MIN;
                    1: return S32_MAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return S32_MAX - 1;
                endcase
            end
            3: return $signed($urandom()) >>> $urandom_range(1, 30);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    // The second bound usually lies near the first so that the span fits and a draw happens.
    function automatic xbig_pkg::t_req random_req();
        xbig_pkg::t_req req;
        longint         b;
        req.op = xbig_pkg::t_op'($urandom_range(0, 3));
        req.first_bound = pick_bound();
        if ($urandom_range(0, 3) == 0) begin
            req.second_bound = pick_bound();
        end else begin
            b = longint'(req.first_bound)
                + (longint'($signed($urandom())) >>> $urandom_range(0, 31));
            if (b > S32_MAX)
                b = S32_MAX;
            if (b < S32_MIN)
                b = S32_MIN;
            req.second_bound = b[31:0];
        end
        return req;
    endfunction

    // Returns at the edge where the beat is accepted; valid stays high if the next beat follows.
    task automatic send_req(input xbig_pkg::t_req req);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= req;
        do @(posedge clk); while (!req_ready);
        sb.note_request(req);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        seed_valid <= 1'b1;
        seed_value <= seed;
        do @(posedge clk); while (!seed_ready);
        sb.load_seed(seed);
        seed_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int   gap;
        rsp_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            sb.check_result(rsp_data);
        end
    end

    initial begin
        xbig_pkg::t_req directed[$];
        logic [31:0]    seed;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        seed_valid = 1'b0;
        seed_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats run from the reset state, before any seed is written.
        directed.push_back(make_req(xbig_pkg::OP_RAW, 0, 0));
        directed.push_back(make_req(xbig_pkg::OP_RAW, -1, -1));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, 0, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, -1, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, S32_MIN, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, 1, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, 2, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, S32_MAX, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, 32'h4000_0001, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BELOW, 7, $urandom()));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, 5, 5));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, S32_MIN, S32_MAX));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, S32_MAX, S32_MIN));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, -10, 10));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, 10, -10));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, S32_MAX, S32_MAX - 3));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, S32_MIN, S32_MIN + 1));
        // A span of exactly 2^31 is too wide; one less still draws.
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, -1073741824, 1073741823));
        directed.push_back(make_req(xbig_pkg::OP_BETWEEN, -1073741824, 1073741822));
        directed.push_back(make_req(xbig_pkg::OP_AVERAGE, S32_MIN, S32_MAX));
        directed.push_back(make_req(xbig_pkg::OP_AVERAGE, -7, 3));
        directed.push_back(make_req(xbig_pkg::OP_AVERAGE, S32_MAX - 1, S32_MAX));
        directed.push_back(make_req(xbig_pkg::OP_AVERAGE, 5, 5));
        directed.push_back(make_req(xbig_pkg::OP_AVERAGE, -2000000000, -1000000000));
        directed.push_back(make_req(xbig_pkg::OP_AVERAGE, S32_MIN, S32_MIN + 2));
        foreach (directed[i])
            send_req(directed[i]);
        req_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: seed = 32'hFFFF_FFFF;
                2: seed = 32'd0;
                3: seed = 32'd1;
                5: seed = 32'h8000_0000;
                default: seed = $urandom();
            endcase
            wait_drained();
            write_seed(seed);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_req(random_req());
            req_valid <= 1'b0;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("** xorshift_bounded_int_generator: PASSED **");
        else
            $display("** xorshift_bounded_int_generator: FAILED **");
        $finish;
    end

    initial begin
        #30ms;
        $display("%0t: timeout", $time);
        $display("** xorshift_bounded_int_generator: FAILED **");
        $finish;
    end

endmodule
